@@ src/fdrd_pkg.sv @@
// shared types and constants of the factorial and dma register device
`timescale 1ns / 1ps
`default_nettype none
package fdrd_pkg;

	typedef enum logic [1:0] {
		OP_READ       = 2'd0,
		OP_WRITE      = 2'd1,
		OP_FACT_DONE  = 2'd2,
		OP_DMA_EXPIRY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FACT,
		ST_DONE
	} state_t;

	// register offsets
	localparam logic [19:0] REG_ID       = 20'h00000;
	localparam logic [19:0] REG_INVERT   = 20'h00004;
	localparam logic [19:0] REG_FACT     = 20'h00008;
	localparam logic [19:0] REG_STATUS   = 20'h00020;
	localparam logic [19:0] REG_IRQ_STAT = 20'h00024;
	localparam logic [19:0] REG_IRQ_RAISE = 20'h00060;
	localparam logic [19:0] REG_IRQ_LOWER = 20'h00064;
	localparam logic [19:0] REG_DMA_SRC  = 20'h00080;
	localparam logic [19:0] REG_DMA_DST  = 20'h00088;
	localparam logic [19:0] REG_DMA_CNT  = 20'h00090;
	localparam logic [19:0] REG_DMA_CMD  = 20'h00098;
	localparam logic [19:0] WIDE_BASE    = 20'h00080;

	localparam logic [3:0]  SIZE_WORD    = 4'd4;
	localparam logic [3:0]  SIZE_DWORD   = 4'd8;

	localparam logic [31:0] ID_VALUE     = 32'h010000ED;
	localparam logic [31:0] IRQ_FACT_BIT = 32'h00000001;
	localparam logic [31:0] IRQ_DMA_BIT  = 32'h00000100;
	localparam int unsigned STATUS_IRQ_POS = 7;
	localparam int unsigned CMD_RUN_POS  = 0;
	localparam int unsigned CMD_DIR_POS  = 1;
	localparam int unsigned CMD_IRQ_POS  = 2;

	localparam logic [63:0] WIN_START    = 64'h40000;
	localparam logic [63:0] WIN_END      = WIN_START + 64'd4096;

	localparam logic [31:0] FACT_LIMIT   = 32'd34;
	localparam int unsigned K_W          = 6;

	typedef struct packed {
		logic latch;
		logic step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic start_fact;
		logic k_zero;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

@@ src/fdrd_ifs.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface fdrd_req_if;
	logic            valid;
	logic            ready;
	fdrd_pkg::op_t   op;
	logic [19:0]     addr;
	logic [3:0]      size;
	logic [63:0]     wdata;
	modport source (output valid, op, addr, size, wdata, input ready);
	modport sink (input valid, op, addr, size, wdata, output ready);
endinterface

interface fdrd_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] rdata;
	logic        irq_level;
	logic        dma_range_error;
	modport source (output valid, rdata, irq_level, dma_range_error, input ready);
	modport sink (input valid, rdata, irq_level, dma_range_error, output ready);
endinterface
`default_nettype wire

@@ src/fdrd_ctl.sv @@
// controller state machine sequencing one transaction at a time
`timescale 1ns / 1ps
`default_nettype none
module fdrd_ctl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire fdrd_pkg::status_t status,
	output fdrd_pkg::cmd_t         cmd
);

	fdrd_pkg::state_t state_q;
	fdrd_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdrd_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			fdrd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = status.start_fact ? fdrd_pkg::ST_FACT : fdrd_pkg::ST_DONE;
				end
			end
			fdrd_pkg::ST_FACT: begin
				if (status.k_zero) begin
					state_next = fdrd_pkg::ST_DONE;
				end
			end
			fdrd_pkg::ST_DONE: begin
				if (status.out_free) begin
					state_next = fdrd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = fdrd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.latch  = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			fdrd_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			fdrd_pkg::ST_FACT: begin
				cmd.step = !status.k_zero;
			end
			fdrd_pkg::ST_DONE: begin
				cmd.commit = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ src/fdrd_dp.sv @@
// datapath: register file, factorial multiplier, range check and result register
`timescale 1ns / 1ps
`default_nettype none
module fdrd_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fdrd_pkg::cmd_t    cmd,
	output fdrd_pkg::status_t      status,
	input  wire fdrd_pkg::op_t     in_op,
	input  wire logic [19:0]       in_addr,
	input  wire logic [3:0]        in_size,
	input  wire logic [63:0]       in_wdata,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [63:0]            out_rdata,
	output logic                   out_irq_level,
	output logic                   out_dma_range_error
);

	// latched transaction
	fdrd_pkg::op_t op_q;
	logic [19:0]   addr_q;
	logic [3:0]    size_q;
	logic [63:0]   wdata_q;

	// factorial iteration
	logic [31:0]                 acc_q;
	logic [fdrd_pkg::K_W-1:0]    k_q;
	logic [31+fdrd_pkg::K_W:0]   prod;

	// architectural registers
	logic [31:0] inverted_store_q;
	logic [31:0] fact_value_q;
	logic        computing_q;
	logic        irq_on_fact_q;
	logic [31:0] irq_pending_q;
	logic [63:0] dma_source_q;
	logic [63:0] dma_dest_q;
	logic [63:0] dma_count_q;
	logic [63:0] dma_command_q;

	// result register
	logic        out_valid_q;
	logic [63:0] rdata_q;
	logic        irq_level_q;
	logic        range_error_q;

	logic        size_ok;
	logic        is_word;
	logic        locked;
	logic [63:0] wval;
	logic [63:0] reg_val;
	logic [63:0] rd_val;
	logic [31:0] irq_next;
	logic [63:0] chk_addr;
	logic [63:0] chk_end;
	logic        range_bad;
	logic        fact_big;
	logic        is_wr;

	assign is_word  = (size_q == fdrd_pkg::SIZE_WORD);
	assign size_ok  = (addr_q < fdrd_pkg::WIDE_BASE) ? is_word
	                : (is_word || size_q == fdrd_pkg::SIZE_DWORD);
	assign locked   = dma_command_q[fdrd_pkg::CMD_RUN_POS];
	assign wval     = is_word ? {32'd0, wdata_q[31:0]} : wdata_q;
	assign is_wr    = (op_q == fdrd_pkg::OP_WRITE) && size_ok;
	assign prod     = acc_q * k_q;
	assign fact_big = (fact_value_q >= fdrd_pkg::FACT_LIMIT);

	always_comb begin
		case (addr_q)
			fdrd_pkg::REG_ID:       reg_val = {32'd0, fdrd_pkg::ID_VALUE};
			fdrd_pkg::REG_INVERT:   reg_val = {32'd0, inverted_store_q};
			fdrd_pkg::REG_FACT:     reg_val = {32'd0, fact_value_q};
			fdrd_pkg::REG_STATUS:   reg_val = {56'd0, irq_on_fact_q, 6'd0, computing_q};
			fdrd_pkg::REG_IRQ_STAT: reg_val = {32'd0, irq_pending_q};
			fdrd_pkg::REG_DMA_SRC:  reg_val = dma_source_q;
			fdrd_pkg::REG_DMA_DST:  reg_val = dma_dest_q;
			fdrd_pkg::REG_DMA_CNT:  reg_val = dma_count_q;
			fdrd_pkg::REG_DMA_CMD:  reg_val = dma_command_q;
			default:                reg_val = '1;
		endcase
	end

	always_comb begin
		if (op_q != fdrd_pkg::OP_READ) begin
			rd_val = '0;
		end else if (!size_ok) begin
			rd_val = '1;
		end else if (is_word) begin
			rd_val = {32'd0, reg_val[31:0]};
		end else begin
			rd_val = reg_val;
		end
	end

	// range of the completing transfer
	assign chk_addr  = dma_command_q[fdrd_pkg::CMD_DIR_POS] ? dma_source_q : dma_dest_q;
	assign chk_end   = chk_addr + dma_count_q;
	assign range_bad = !((chk_addr >= fdrd_pkg::WIN_START) && (chk_addr < fdrd_pkg::WIN_END)
	                   && (chk_end > chk_addr) && (chk_end >= fdrd_pkg::WIN_START)
	                   && (chk_end < fdrd_pkg::WIN_END));

	always_comb begin
		irq_next = irq_pending_q;
		case (op_q)
			fdrd_pkg::OP_WRITE: begin
				if (size_ok && addr_q == fdrd_pkg::REG_IRQ_RAISE) begin
					irq_next = irq_pending_q | wval[31:0];
				end else if (size_ok && addr_q == fdrd_pkg::REG_IRQ_LOWER) begin
					irq_next = irq_pending_q & ~wval[31:0];
				end
			end
			fdrd_pkg::OP_FACT_DONE: begin
				if (computing_q && irq_on_fact_q) begin
					irq_next = irq_pending_q | fdrd_pkg::IRQ_FACT_BIT;
				end
			end
			fdrd_pkg::OP_DMA_EXPIRY: begin
				if (locked && dma_command_q[fdrd_pkg::CMD_IRQ_POS]) begin
					irq_next = irq_pending_q | fdrd_pkg::IRQ_DMA_BIT;
				end
			end
			default: begin
				irq_next = irq_pending_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= in_op;
			addr_q  <= in_addr;
			size_q  <= in_size;
			wdata_q <= in_wdata;
			acc_q   <= fact_big ? 32'd0 : 32'd1;
			k_q     <= fact_big ? '0 : fact_value_q[fdrd_pkg::K_W-1:0];
		end else if (cmd.step) begin
			acc_q <= prod[31:0];
			k_q   <= k_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverted_store_q <= '0;
			fact_value_q     <= '0;
			computing_q      <= 1'b0;
			irq_on_fact_q    <= 1'b0;
			irq_pending_q    <= '0;
			dma_source_q     <= '0;
			dma_dest_q       <= '0;
			dma_count_q      <= '0;
			dma_command_q    <= '0;
		end else if (cmd.commit) begin
			irq_pending_q <= irq_next;
			if (is_wr) begin
				case (addr_q)
					fdrd_pkg::REG_INVERT: inverted_store_q <= ~wval[31:0];
					fdrd_pkg::REG_FACT: begin
						if (!computing_q) begin
							fact_value_q <= wval[31:0];
							computing_q  <= 1'b1;
						end
					end
					fdrd_pkg::REG_STATUS:  irq_on_fact_q <= wval[fdrd_pkg::STATUS_IRQ_POS];
					fdrd_pkg::REG_DMA_SRC: if (!locked) dma_source_q <= wval;
					fdrd_pkg::REG_DMA_DST: if (!locked) dma_dest_q <= wval;
					fdrd_pkg::REG_DMA_CNT: if (!locked) dma_count_q <= wval;
					fdrd_pkg::REG_DMA_CMD: begin
						if (!locked && wval[fdrd_pkg::CMD_RUN_POS]) begin
							dma_command_q <= wval;
						end
					end
					default: begin
						dma_command_q <= dma_command_q;
					end
				endcase
			end else if (op_q == fdrd_pkg::OP_FACT_DONE && computing_q) begin
				fact_value_q <= acc_q;
				computing_q  <= 1'b0;
			end else if (op_q == fdrd_pkg::OP_DMA_EXPIRY && locked) begin
				dma_command_q[fdrd_pkg::CMD_RUN_POS] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rdata_q       <= rd_val;
			irq_level_q   <= |irq_next;
			range_error_q <= (op_q == fdrd_pkg::OP_DMA_EXPIRY) && locked && range_bad;
		end
	end

	assign status.start_fact = (in_op == fdrd_pkg::OP_FACT_DONE) && computing_q;
	assign status.k_zero     = (k_q == '0);
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid           = out_valid_q;
	assign out_rdata           = rdata_q;
	assign out_irq_level       = irq_level_q;
	assign out_dma_range_error = range_error_q;

endmodule
`default_nettype wire

@@ src/factorial_dma_register_device.sv @@
// Register block with a factorial unit and a DMA command interface.
// The req channel carries one transaction per bus read, bus write,
// factorial finished event or DMA timer expiry; the rsp channel returns
// exactly one result per request: read data, the interrupt level after
// the transaction and the DMA range error flag.
// One transaction is in work at a time. A read, write or DMA expiry is
// latched on acceptance and committed to the response register from the
// done state, as is a factorial finished event that finds nothing computing.
// A factorial finished event for operand n first passes through the
// factorial state, where the 32 by 6 bit multiplier is stepped once per
// operand value from n down to 1 for n below 34 and not at all otherwise.
// A new request is taken as soon as the previous result sits in the
// response register; if the receiver stalls, the next result waits in
// the datapath until the response register is free.
// Reset (arst_n low) clears the architectural registers to zero, empties
// the response register and returns the controller to idle.
`timescale 1ns / 1ps
`default_nettype none
module factorial_dma_register_device (
	input  wire logic clk,
	input  wire logic arst_n,
	fdrd_req_if.sink  req,
	fdrd_rsp_if.source rsp
);

	fdrd_pkg::cmd_t    cmd;
	fdrd_pkg::status_t status;

	fdrd_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	fdrd_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.in_op               (req.op),
		.in_addr             (req.addr),
		.in_size             (req.size),
		.in_wdata            (req.wdata),
		.out_valid           (rsp.valid),
		.out_ready           (rsp.ready),
		.out_rdata           (rsp.rdata),
		.out_irq_level       (rsp.irq_level),
		.out_dma_range_error (rsp.dma_range_error)
	);

endmodule
`default_nettype wire

@@ src/fdrd_checker.sv @@
// port level checks of the factorial and dma register device
`timescale 1ns / 1ps
`default_nettype none
module fdrd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [63:0] rsp_rdata,
	input wire logic        rsp_irq_level,
	input wire logic        rsp_dma_range_error
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_rdata) && $stable(rsp_irq_level)
			&& $stable(rsp_dma_range_error))
		else $error("response payload changed while stalled");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second transaction taken while one is in work");

	a_range_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_dma_range_error |-> rsp_rdata == 64'd0)
		else $error("range error flagged on a read transaction");

endmodule

bind factorial_dma_register_device fdrd_checker u_fdrd_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_rdata           (rsp.rdata),
	.rsp_irq_level       (rsp.irq_level),
	.rsp_dma_range_error (rsp.dma_range_error)
);
`default_nettype wire
